// File: src/psch_pkg.sv
// Shared widths, defaults and types for the priority scheduler.
package psch_pkg;

   localparam int JOBS_DEFAULT = 16;
   localparam int ARRIVAL_W    = 16;
   localparam int BURST_W      = 16;
   localparam int URGENCY_W    = 8;
   localparam int JOBNUM_W     = 5;
   localparam int WAIT_W       = 20;
   localparam int TURN_W       = 21;
   localparam int DELAY_W      = 20;

   typedef struct packed {
      logic [ARRIVAL_W-1:0] arrival;
      logic [BURST_W-1:0]   burst;
      logic [URGENCY_W-1:0] urgency;
   } psch_entry_type;

   typedef struct packed {
      logic clear;
      logic update;
      logic done;
   } psch_pick_ctl_type;

endpackage

// File: src/psch_if.sv
// Job request and job result channel interfaces.
interface psch_req_if import psch_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ARRIVAL_W-1:0] arrival_time;
   logic [BURST_W-1:0]   burst_length;
   logic [URGENCY_W-1:0] urgency;
   logic                 final_job;

   modport source (output valid, arrival_time, burst_length, urgency, final_job,
                   input ready);
   modport sink   (input valid, arrival_time, burst_length, urgency, final_job,
                   output ready);
endinterface

interface psch_rsp_if import psch_pkg::*;;
   logic                valid;
   logic                ready;
   logic [JOBNUM_W-1:0] job_number;
   logic [WAIT_W-1:0]   wait_ticks;
   logic [TURN_W-1:0]   turnaround_ticks;
   logic [DELAY_W-1:0]  first_run_delay;
   logic                last_result;

   modport source (output valid, job_number, wait_ticks, turnaround_ticks,
                   first_run_delay, last_result, input ready);
   modport sink   (input valid, job_number, wait_ticks, turnaround_ticks,
                   first_run_delay, last_result, output ready);
endinterface

// File: src/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler top level: job loading, sequencer and result register.
//
// req_chan carries one job per transaction (arrival, burst, urgency, final_job).
// Jobs are stored in load order, one per cycle, up to MAX_JOBS; extra jobs are
// dropped. The transaction with final_job set closes the set and starts the
// schedule; req_chan.ready stays low until the last result has been loaded
// into the output register.
// Each decision streams all N stored jobs through one compare unit, one job
// per cycle, read from the job memory, and streams them again when no job is
// ready and the clock jumps to the next arrival. One rsp_chan transaction per
// job then follows in completion order, the last one with last_result set.
// rsp_chan has an output register; a stall on rsp_chan.ready holds the
// sequencer before the next result, but the last result can wait while the
// next job set is already loading.
// Synchronous reset empties the job set and drops any pending result; the
// job memory itself is not cleared.
module nonpreemptive_priority_scheduler import psch_pkg::*; #(
   parameter int MAX_JOBS = JOBS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   psch_req_if.sink   req_chan,
   psch_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CLK_W = ARRIVAL_W + CNT_W;

   typedef enum logic [2:0] {
      LOAD,
      ISSUE,
      SETTLE,
      DECIDE,
      EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [CLK_W-1:0]    sim_clock_ff, sim_clock_in;
   logic [MAX_JOBS-1:0] done_ff, done_in;
   logic [CLK_W-1:0]    delay_ff, delay_in;
   logic [CLK_W-1:0]    turn_ff, turn_in;
   logic [IDX_W-1:0]    job_idx_ff, job_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [JOBNUM_W-1:0] job_number_ff, job_number_in;
   logic [WAIT_W-1:0]   wait_ff, wait_in;
   logic [TURN_W-1:0]   turnaround_ff, turnaround_in;
   logic [DELAY_W-1:0]  first_delay_ff, first_delay_in;
   logic                last_ff, last_in;

   logic                req_accept;
   logic                wr_en;
   psch_entry_type      wr_entry;
   psch_entry_type      rd_entry;
   logic                rd_valid;
   logic [IDX_W-1:0]    rd_idx;
   psch_pick_ctl_type   pick_ctl;
   logic                best_found;
   logic [IDX_W-1:0]    best_idx;
   psch_entry_type      best_entry;
   logic [ARRIVAL_W-1:0] min_arrival;
   logic [CLK_W-1:0]    finish_tick;

   assign req_chan.ready = (state_ff == LOAD);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign wr_en          = req_accept && (count_ff < CNT_W'(MAX_JOBS));
   assign wr_entry       = '{arrival: req_chan.arrival_time,
                             burst:   req_chan.burst_length,
                             urgency: req_chan.urgency};

   psch_store #(.MAX_JOBS(MAX_JOBS), .IDX_W(IDX_W)) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_idx     (count_ff[IDX_W-1:0]),
      .wr_entry   (wr_entry),
      .rd_en      (state_ff == ISSUE),
      .rd_idx     (scan_idx_ff),
      .rd_entry   (rd_entry),
      .rd_valid   (rd_valid),
      .rd_idx_out (rd_idx)
   );

   assign pick_ctl.clear  = (state_ff == ISSUE) && (scan_idx_ff == '0);
   assign pick_ctl.update = rd_valid;
   assign pick_ctl.done   = done_ff[rd_idx];

   psch_pick #(.IDX_W(IDX_W), .CLK_W(CLK_W)) u_pick (
      .clock       (clock),
      .reset       (reset),
      .ctl         (pick_ctl),
      .sim_clock   (sim_clock_ff),
      .entry       (rd_entry),
      .entry_idx   (rd_idx),
      .best_found  (best_found),
      .best_idx    (best_idx),
      .best_entry  (best_entry),
      .min_arrival (min_arrival)
   );

   assign finish_tick = sim_clock_ff + CLK_W'(best_entry.burst);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      scan_idx_in    = scan_idx_ff;
      sim_clock_in   = sim_clock_ff;
      done_in        = done_ff;
      delay_in       = delay_ff;
      turn_in        = turn_ff;
      job_idx_in     = job_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      job_number_in  = job_number_ff;
      wait_in        = wait_ff;
      turnaround_in  = turnaround_ff;
      first_delay_in = first_delay_ff;
      last_in        = last_ff;
      unique case (state_ff)
         LOAD: begin
            if (req_accept) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_chan.final_job) begin
                  remain_in    = count_in;
                  scan_idx_in  = '0;
                  sim_clock_in = '0;
                  state_in     = ISSUE;
               end
            end
         end
         ISSUE: begin
            if (scan_idx_ff == IDX_W'(count_ff - CNT_W'(1))) begin
               state_in = SETTLE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         SETTLE: begin
            state_in = DECIDE;
         end
         DECIDE: begin
            if (best_found) begin
               delay_in          = sim_clock_ff - CLK_W'(best_entry.arrival);
               turn_in           = finish_tick - CLK_W'(best_entry.arrival);
               sim_clock_in      = finish_tick;
               done_in[best_idx] = 1'b1;
               remain_in         = remain_ff - CNT_W'(1);
               job_idx_in        = best_idx;
               state_in          = EMIT;
            end else begin
               sim_clock_in = CLK_W'(min_arrival);
               scan_idx_in  = '0;
               state_in     = ISSUE;
            end
         end
         EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               job_number_in  = JOBNUM_W'(job_idx_ff) + JOBNUM_W'(1);
               wait_in        = WAIT_W'(delay_ff);
               turnaround_in  = TURN_W'(turn_ff);
               first_delay_in = DELAY_W'(delay_ff);
               last_in        = (remain_ff == '0);
               if (remain_ff == '0) begin
                  count_in = '0;
                  done_in  = '0;
                  state_in = LOAD;
               end else begin
                  scan_idx_in = '0;
                  state_in    = ISSUE;
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         count_ff     <= '0;
         remain_ff    <= '0;
         scan_idx_ff  <= '0;
         sim_clock_ff <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         scan_idx_ff  <= scan_idx_in;
         sim_clock_ff <= sim_clock_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      delay_ff       <= delay_in;
      turn_ff        <= turn_in;
      job_idx_ff     <= job_idx_in;
      job_number_ff  <= job_number_in;
      wait_ff        <= wait_in;
      turnaround_ff  <= turnaround_in;
      first_delay_ff <= first_delay_in;
      last_ff        <= last_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.job_number       = job_number_ff;
   assign rsp_chan.wait_ticks       = wait_ff;
   assign rsp_chan.turnaround_ticks = turnaround_ff;
   assign rsp_chan.first_run_delay  = first_delay_ff;
   assign rsp_chan.last_result      = last_ff;

endmodule

// File: src/psch_store.sv
// Job table memory with one write port and one registered read port.
module psch_store import psch_pkg::*; #(
   parameter int MAX_JOBS = JOBS_DEFAULT,
   parameter int IDX_W    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_idx,
   input  psch_entry_type       wr_entry,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_idx,
   output psch_entry_type       rd_entry,
   output logic                 rd_valid,
   output logic [IDX_W-1:0]     rd_idx_out
);

   psch_entry_type mem [MAX_JOBS];
   psch_entry_type rd_entry_ff;
   logic           rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_idx];
      end
      rd_idx_ff <= rd_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_entry   = rd_entry_ff;
   assign rd_valid   = rd_valid_ff;
   assign rd_idx_out = rd_idx_ff;

endmodule

// File: src/psch_pick.sv
// Shared compare unit: folds one job per cycle into best-ready and earliest-pending.
module psch_pick import psch_pkg::*; #(
   parameter int IDX_W = 4,
   parameter int CLK_W = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psch_pick_ctl_type    ctl,
   input  logic [CLK_W-1:0]     sim_clock,
   input  psch_entry_type       entry,
   input  logic [IDX_W-1:0]     entry_idx,
   output logic                 best_found,
   output logic [IDX_W-1:0]     best_idx,
   output psch_entry_type       best_entry,
   output logic [ARRIVAL_W-1:0] min_arrival
);

   logic                 found_ff;
   logic                 found_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     idx_in;
   psch_entry_type       best_ff;
   psch_entry_type       best_in;
   logic                 any_ff;
   logic                 any_in;
   logic [ARRIVAL_W-1:0] min_ff;
   logic [ARRIVAL_W-1:0] min_in;
   logic                 is_ready;
   logic                 better;

   always_comb begin
      is_ready = !ctl.done && (CLK_W'(entry.arrival) <= sim_clock);
      better   = !found_ff || (entry.urgency < best_ff.urgency) ||
                 ((entry.urgency == best_ff.urgency) && (entry.arrival < best_ff.arrival));
      found_in = found_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      any_in   = any_ff;
      min_in   = min_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
         any_in   = 1'b0;
      end else if (ctl.update) begin
         if (is_ready && better) begin
            found_in = 1'b1;
            idx_in   = entry_idx;
            best_in  = entry;
         end
         if (!ctl.done && (!any_ff || (entry.arrival < min_ff))) begin
            any_in = 1'b1;
            min_in = entry.arrival;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         found_ff <= found_in;
         any_ff   <= any_in;
      end
      idx_ff  <= idx_in;
      best_ff <= best_in;
      min_ff  <= min_in;
   end

   assign best_found  = found_ff;
   assign best_idx    = idx_ff;
   assign best_entry  = best_ff;
   assign min_arrival = min_ff;

endmodule

// File: sim/schedule_checker.sv
`timescale 1ns / 100ps
// Checker for the priority scheduler: predicts each schedule and compares the results.
module schedule_checker import psch_pkg::*; #(
   parameter int MAX_JOBS = JOBS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   psch_req_if  req_chan,
   psch_rsp_if  rsp_chan,
   output int   error_count,
   output int   results_due
);

   typedef struct packed {
      logic [JOBNUM_W-1:0] job_number;
      logic [WAIT_W-1:0]   wait_ticks;
      logic [TURN_W-1:0]   turnaround_ticks;
      logic [DELAY_W-1:0]  first_run_delay;
      logic                last_result;
   } job_result_type;

   logic [ARRIVAL_W-1:0] arrival_of [MAX_JOBS];
   logic [BURST_W-1:0]   burst_of   [MAX_JOBS];
   logic [URGENCY_W-1:0] urgency_of [MAX_JOBS];
   bit                   finished   [MAX_JOBS];
   int                   jobs_held;
   job_result_type       completions[$];
   job_result_type       oldest;

   function automatic void run_schedule();
      logic [31:0]    now;
      logic [31:0]    start_tick;
      logic [31:0]    turn;
      logic [31:0]    earliest;
      bit             found;
      int             left;
      int             pick;
      job_result_type outcome;
      now  = '0;
      left = jobs_held;
      while (left > 0) begin
         found = 1'b0;
         earliest = '0;
         for (int i = 0; i < jobs_held; i++) begin
            if (!finished[i] && (!found || 32'(arrival_of[i]) < earliest)) begin
               earliest = 32'(arrival_of[i]);
               found = 1'b1;
            end
         end
         if (earliest > now) now = earliest;
         pick = -1;
         for (int i = 0; i < jobs_held; i++) begin
            if (finished[i] || 32'(arrival_of[i]) > now) continue;
            if (pick < 0 || urgency_of[i] < urgency_of[pick] ||
                (urgency_of[i] == urgency_of[pick] && arrival_of[i] < arrival_of[pick]))
               pick = i;
         end
         start_tick = now;
         now = now + 32'(burst_of[pick]);
         turn = now - 32'(arrival_of[pick]);
         finished[pick] = 1'b1;
         left--;
         outcome.job_number       = JOBNUM_W'(pick + 1);
         outcome.wait_ticks       = WAIT_W'(turn - 32'(burst_of[pick]));
         outcome.turnaround_ticks = TURN_W'(turn);
         outcome.first_run_delay  = DELAY_W'(start_tick - 32'(arrival_of[pick]));
         outcome.last_result      = (left == 0);
         completions.push_back(outcome);
      end
      finished  = '{default: 1'b0};
      jobs_held = 0;
   endfunction

   function automatic void compare_field(string name, logic [31:0] expected,
                                         logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         jobs_held   = 0;
         finished    = '{default: 1'b0};
         completions.delete();
         error_count = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (completions.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual job %0d",
                        $time, rsp_chan.job_number);
               error_count++;
            end else begin
               oldest = completions.pop_front();
               compare_field("job_number", 32'(oldest.job_number),
                             32'(rsp_chan.job_number));
               compare_field("wait_ticks", 32'(oldest.wait_ticks),
                             32'(rsp_chan.wait_ticks));
               compare_field("turnaround_ticks", 32'(oldest.turnaround_ticks),
                             32'(rsp_chan.turnaround_ticks));
               compare_field("first_run_delay", 32'(oldest.first_run_delay),
                             32'(rsp_chan.first_run_delay));
               compare_field("last_result", 32'(oldest.last_result),
                             32'(rsp_chan.last_result));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (jobs_held < MAX_JOBS) begin
               arrival_of[jobs_held] = req_chan.arrival_time;
               burst_of[jobs_held]   = req_chan.burst_length;
               urgency_of[jobs_held] = req_chan.urgency;
               finished[jobs_held]   = 1'b0;
               jobs_held++;
            end
            if (req_chan.final_job) run_schedule();
         end
      end
      results_due = completions.size();
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the priority scheduler testbench: clock, reset, job stimulus and verdict.
module testbench import psch_pkg::*;;

   localparam int JOB_LIMIT    = JOBS_DEFAULT;
   localparam int RANDOM_JOBS  = 430;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 100;

   logic clock;
   logic reset;
   bit   quiet;
   int   error_count;
   int   results_due;
   int   sent;
   int   idle_cycles = 0;

   psch_req_if req_chan();
   psch_rsp_if rsp_chan();

   nonpreemptive_priority_scheduler #(.MAX_JOBS(JOB_LIMIT)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   schedule_checker #(.MAX_JOBS(JOB_LIMIT)) u_schedule_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .error_count (error_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && (quiet || $urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   task automatic send_job(input logic [ARRIVAL_W-1:0] arrival,
                           input logic [BURST_W-1:0] burst,
                           input logic [URGENCY_W-1:0] urgency, input bit last);
      while (!quiet && $urandom_range(99) < 8) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.arrival_time <= arrival;
      req_chan.burst_length <= burst;
      req_chan.urgency      <= urgency;
      req_chan.final_job    <= last;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      @(posedge clock);
   endtask

   task automatic random_job_set();
      int                   count;
      logic [ARRIVAL_W-1:0] arrival;
      logic [BURST_W-1:0]   burst;
      logic [URGENCY_W-1:0] urgency;
      case ($urandom_range(9)) inside
         0:       count = $urandom_range(JOB_LIMIT + 1, JOB_LIMIT + 4);
         1, 2:    count = $urandom_range(9, JOB_LIMIT);
         default: count = $urandom_range(1, 8);
      endcase
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0:       arrival = ARRIVAL_W'($urandom);
            3:       arrival = '0;
            default: arrival = ARRIVAL_W'($urandom_range(0, 300));
         endcase
         case ($urandom_range(3))
            0:       burst = BURST_W'($urandom);
            1:       burst = '0;
            default: burst = BURST_W'($urandom_range(1, 60));
         endcase
         if ($urandom_range(2) == 0)
            urgency = URGENCY_W'($urandom);
         else
            urgency = URGENCY_W'($urandom_range(0, 3));
         send_job(arrival, burst, urgency, i == count - 1);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      quiet                 = 1'b0;
      sent                  = 0;
      req_chan.valid        = 1'b0;
      req_chan.arrival_time = '0;
      req_chan.burst_length = '0;
      req_chan.urgency      = '0;
      req_chan.final_job    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      send_job(16'd5, 16'd3, 8'd7, 1'b0);
      send_job(16'd2, 16'd4, 8'd7, 1'b0);
      send_job(16'd2, 16'd1, 8'd7, 1'b0);
      send_job(16'd0, 16'd0, 8'd0, 1'b0);
      send_job(16'd100, 16'd10, 8'd0, 1'b1);
      drain_results();
      for (int i = 0; i < JOB_LIMIT + 2; i++)
         send_job(16'h0000, 16'hFFFF, i[0] ? 8'hFF : 8'h00, i == JOB_LIMIT + 1);
      drain_results();

      sent = 0;
      while (sent < RANDOM_JOBS) begin
         quiet = (sent >= 150 && sent < 260);
         random_job_set();
         if ($urandom_range(5) == 0) drain_results();
      end
      quiet = 1'b0;
      req_chan.valid <= 1'b0;

      do @(negedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && results_due == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
src/psch_pkg.sv
src/psch_if.sv
src/psch_store.sv
src/psch_pick.sv
src/nonpreemptive_priority_scheduler.sv
sim/schedule_checker.sv
sim/testbench.sv
